[rtl/peg_pkg.sv]
// ----------------------------------------------------------------------------
// peg_pkg
// Shared types and constants for the pitch envelope generator.
// ----------------------------------------------------------------------------
package peg_pkg;

  localparam int NUM_STAGES_DEF = 4;
  localparam int NUM_WORDS      = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;
  localparam int LEVEL_W        = 16;
  localparam int PHASE_W        = 16;
  localparam int COUNT_W        = 8;
  localparam int OUT_DATA_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STAGE0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_STAGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd5;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_START   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic take;
    logic step;
    logic mul;
    logic add;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic adv_run;
    logic inc_zero;
    logic carry;
    logic rem_zero;
  } sts_t;

endpackage

[rtl/peg_ctrl.sv]
// ----------------------------------------------------------------------------
// peg_ctrl
// Sequencer: takes one request, runs the phase stepping loop, the scale
// multiply, the add and the result load, and tracks the output register.
// ----------------------------------------------------------------------------
module peg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  peg_pkg::sts_t sts_i,
  output peg_pkg::cmd_t cmd_o
);
  import peg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take;

  assign take = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (!sts_i.adv_run) begin
            state_d = ST_OUT;
          end else if (sts_i.inc_zero) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (sts_i.carry) begin
          state_d = ST_OUT;
        end else if (sts_i.rem_zero) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_STEP: cmd_o.step = 1'b1;
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_ADD:  cmd_o.add  = 1'b1;
      ST_OUT:  cmd_o.load_out = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("result overwrote a pending output");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_short_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !sts_i.adv_run) |=> (state_q == ST_OUT))
    else $error("start or ignored request entered the stepping loop");

  a_loop_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && sts_i.carry) |=> (state_q == ST_OUT))
    else $error("carry did not end the stepping loop");

endmodule

[rtl/peg_dp.sv]
// ----------------------------------------------------------------------------
// peg_dp
// Datapath: configuration registers, envelope state, phase accumulator,
// step counter, scale multiplier and output register.
// ----------------------------------------------------------------------------
module peg_dp #(
  parameter int NUM_STAGES = peg_pkg::NUM_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [peg_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [peg_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_op_i,
  input  logic [peg_pkg::COUNT_W-1:0]          in_elapsed_i,
  input  peg_pkg::cmd_t                        cmd_i,
  output peg_pkg::sts_t                        sts_o,
  output logic [peg_pkg::OUT_DATA_W-1:0]       out_data_o
);
  import peg_pkg::*;

  localparam int SW = $clog2(NUM_STAGES + 1);

  logic [CFG_DATA_W-1:0] word_q [NUM_WORDS];
  logic                  start_stage_q;
  logic [LEVEL_W-1:0]    start_level_q;

  logic [SW-1:0]         stage_q;
  logic                  active_q;
  logic [PHASE_W-1:0]    phase_q;
  logic [LEVEL_W-1:0]    base_q;
  logic [LEVEL_W-1:0]    delta_q;
  logic [LEVEL_W-1:0]    cur_q;
  logic [COUNT_W-1:0]    left_q;
  logic [15:0]           rem_q;
  logic [LEVEL_W-1:0]    prod_q;
  logic                  acc_q;

  logic [LEVEL_W-1:0]    res_level_q;
  logic [2:0]            res_stage_q;
  logic                  res_run_q;
  logic                  res_acc_q;

  logic [CFG_DATA_W-1:0] word_cur, word_nxt, word_start;
  logic [SW+1:0]         ext_cur, ext_nxt;
  logic [SW-1:0]         stage_inc;
  logic                  fin;
  logic [PHASE_W:0]      sum;
  logic [LEVEL_W-1:0]    base_nxt;
  logic [COUNT_W-1:0]    catchup;
  logic [15:0]           rem0;
  logic                  adv_ok;
  logic signed [32:0]    prod_w;
  logic [SW+2:0]         stage_ext;

  assign stage_inc = stage_q + SW'(1);
  assign fin       = stage_inc >= SW'(NUM_STAGES);
  assign ext_cur   = {2'b00, stage_q};
  assign ext_nxt   = {2'b00, stage_inc};

  always_comb begin
    if (ext_cur[SW+1:2] != '0) begin
      word_cur = '0;
    end else begin
      word_cur = word_q[stage_q[1:0]];
    end
    if (ext_nxt[SW+1:2] != '0) begin
      word_nxt = '0;
    end else begin
      word_nxt = word_q[stage_inc[1:0]];
    end
    word_start = word_q[{1'b0, start_stage_q}];
  end

  assign sum      = {1'b0, phase_q} + {1'b0, word_cur[31:16]};
  assign base_nxt = base_q + delta_q;
  assign catchup  = in_elapsed_i - COUNT_W'(1);
  assign rem0     = {8'b0, left_q} + {{8{catchup[7]}}, catchup};
  assign adv_ok   = (in_op_i == OP_ADVANCE) && active_q &&
                    (stage_q < SW'(NUM_STAGES)) && (in_elapsed_i != '0);
  assign prod_w   = $signed({{17{delta_q[LEVEL_W-1]}}, delta_q}) *
                    $signed({17'b0, phase_q});

  assign sts_o.adv_run  = adv_ok;
  assign sts_o.inc_zero = (word_cur[31:16] == '0);
  assign sts_o.carry    = sum[PHASE_W];
  assign sts_o.rem_zero = (rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        word_q[i] <= '0;
      end
      start_stage_q <= 1'b0;
      start_level_q <= '0;
      stage_q       <= '0;
      active_q      <= 1'b0;
      phase_q       <= '0;
      base_q        <= '0;
      delta_q       <= '0;
      cur_q         <= '0;
      left_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < REG_START_STAGE) begin
          word_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        end else if (cfg_idx_i == REG_START_STAGE) begin
          start_stage_q <= cfg_wdata_i[0];
        end else if (cfg_idx_i == REG_START_LEVEL) begin
          start_level_q <= cfg_wdata_i[LEVEL_W-1:0];
        end
      end
      if (cmd_i.take && in_op_i == OP_START) begin
        stage_q  <= SW'(start_stage_q);
        base_q   <= start_level_q;
        cur_q    <= start_level_q;
        left_q   <= '0;
        active_q <= 1'b1;
        delta_q  <= word_start[47:32] - start_level_q;
        phase_q  <= word_start[15:0];
      end
      if (cmd_i.step) begin
        if (sum[PHASE_W]) begin
          left_q  <= rem_q[COUNT_W-1:0];
          base_q  <= base_nxt;
          cur_q   <= base_nxt;
          stage_q <= stage_inc;
          if (fin) begin
            phase_q  <= '0;
            active_q <= 1'b0;
          end else begin
            delta_q <= word_nxt[47:32] - base_nxt;
            phase_q <= word_nxt[15:0];
          end
        end else begin
          phase_q <= sum[PHASE_W-1:0];
        end
      end
      if (cmd_i.mul) begin
        left_q <= '0;
      end
      if (cmd_i.add) begin
        cur_q <= base_q + prod_q;
      end
    end
  end

  assign stage_ext = {3'b000, stage_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rem_q <= rem0;
      acc_q <= (in_op_i == OP_START) || adv_ok;
    end
    if (cmd_i.step && !sum[PHASE_W]) begin
      rem_q <= rem_q - 16'd1;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_w[31:16];
    end
    if (cmd_i.load_out) begin
      res_level_q <= cur_q;
      res_stage_q <= stage_ext[2:0];
      res_run_q   <= active_q;
      res_acc_q   <= acc_q;
    end
  end

  assign out_data_o = {3'b000, res_acc_q, res_run_q, res_stage_q, res_level_q};

endmodule

[rtl/pitch_envelope_generator.sv]
// ----------------------------------------------------------------------------
// pitch_envelope_generator
// Four-stage pitch envelope with a stepped 16-bit phase accumulator.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tuser: operation; tdata: elapsed
//   m_axis   out  m_axis_tvalid/tready      tdata: offset, stage, running, acc
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Start and ignored requests go straight to the result load. An advance runs
// one loop pass per accumulator step (leftover count plus signed catch-up plus
// one, at most 65536; a phase carry ends the loop and skips multiply and add),
// then multiply, add and result load; a zero increment skips the loop.
// One request is in work at a time; a new one is taken while the previous
// result waits in the output register. After reset the envelope is inactive.
// ----------------------------------------------------------------------------
module pitch_envelope_generator #(
  parameter int NUM_STAGES = peg_pkg::NUM_STAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [peg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [peg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] period_count
  input  logic [0:0]                     s_axis_tuser,  // [0] operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] pitch_offset, [18:16] stage_now, [19] running, [20] accepted
  output logic [peg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import peg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  peg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  peg_dp #(
    .NUM_STAGES (NUM_STAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser[0]),
    .in_elapsed_i (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_data_o   (m_axis_tdata)
  );

endmodule
